// File: hw/rtl/bpt_pkg.sv
// Shared types, constants and curve tables for the battery percent tracker.
package bpt_pkg;

    localparam int unsigned CurveLen = 100;

    localparam logic [6:0]  PCT_INVALID = 7'd101;
    localparam logic [6:0]  PCT_FULL    = 7'd100;
    localparam logic [6:0]  IDX_LAST    = 7'd99;
    localparam logic [12:0] DIS_MIN_MV  = 13'd3391;

    // Reset values of the configuration registers
    localparam logic [6:0] RST_HOLD_THR = 7'd75;
    localparam logic [7:0] RST_HOLD_LIM = 8'd1;
    localparam logic [6:0] RST_LOG_LIM  = 7'd20;

    // Configuration register indexes
    localparam logic [1:0] REG_HOLD_THR = 2'd0;
    localparam logic [1:0] REG_HOLD_LIM = 2'd1;
    localparam logic [1:0] REG_LOG_LIM  = 2'd2;

    // Supply state codes
    localparam logic [1:0] SUP_BATTERY  = 2'd0;
    localparam logic [1:0] SUP_CHARGING = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_UPD  = 3'b100
    } t_fsm;

    // Per-block tracking state kept in RAM
    typedef struct packed {
        logic [6:0] display;
        logic       first;
        logic [7:0] hold;
    } t_state;

    localparam int unsigned StateW = $bits(t_state);

    localparam logic [12:0] CURVE_DIS [CurveLen] = '{
        13'd3391, 13'd3409, 13'd3423, 13'd3435, 13'd3447,
        13'd3459, 13'd3469, 13'd3478, 13'd3488, 13'd3497,
        13'd3505, 13'd3513, 13'd3521, 13'd3528, 13'd3535,
        13'd3541, 13'd3548, 13'd3554, 13'd3560, 13'd3566,
        13'd3571, 13'd3576, 13'd3582, 13'd3587, 13'd3593,
        13'd3598, 13'd3604, 13'd3609, 13'd3615, 13'd3621,
        13'd3627, 13'd3634, 13'd3641, 13'd3648, 13'd3655,
        13'd3663, 13'd3671, 13'd3679, 13'd3688, 13'd3697,
        13'd3706, 13'd3716, 13'd3725, 13'd3735, 13'd3744,
        13'd3753, 13'd3762, 13'd3770, 13'd3778, 13'd3785,
        13'd3792, 13'd3799, 13'd3805, 13'd3811, 13'd3817,
        13'd3822, 13'd3828, 13'd3833, 13'd3838, 13'd3844,
        13'd3849, 13'd3853, 13'd3858, 13'd3863, 13'd3867,
        13'd3872, 13'd3877, 13'd3883, 13'd3891, 13'd3900,
        13'd3910, 13'd3921, 13'd3932, 13'd3943, 13'd3954,
        13'd3964, 13'd3974, 13'd3977, 13'd3980, 13'd3983,
        13'd3986, 13'd3990, 13'd3993, 13'd3996, 13'd3999,
        13'd4000, 13'd4003, 13'd4006, 13'd4009, 13'd4013,
        13'd4019, 13'd4028, 13'd4038, 13'd4049, 13'd4062,
        13'd4076, 13'd4090, 13'd4107, 13'd4125, 13'd4156
    };

    localparam logic [12:0] CURVE_CHG [CurveLen] = '{
        13'd3380, 13'd3495, 13'd3531, 13'd3547, 13'd3556,
        13'd3564, 13'd3572, 13'd3579, 13'd3588, 13'd3596,
        13'd3605, 13'd3613, 13'd3622, 13'd3631, 13'd3639,
        13'd3646, 13'd3655, 13'd3662, 13'd3668, 13'd3675,
        13'd3681, 13'd3687, 13'd3692, 13'd3697, 13'd3701,
        13'd3706, 13'd3710, 13'd3714, 13'd3719, 13'd3724,
        13'd3729, 13'd3734, 13'd3739, 13'd3744, 13'd3750,
        13'd3756, 13'd3762, 13'd3769, 13'd3776, 13'd3784,
        13'd3792, 13'd3800, 13'd3808, 13'd3819, 13'd3827,
        13'd3836, 13'd3845, 13'd3855, 13'd3865, 13'd3874,
        13'd3883, 13'd3892, 13'd3900, 13'd3908, 13'd3916,
        13'd3923, 13'd3930, 13'd3936, 13'd3943, 13'd3949,
        13'd3955, 13'd3960, 13'd3965, 13'd3970, 13'd3975,
        13'd3980, 13'd3985, 13'd3989, 13'd3994, 13'd3999,
        13'd4003, 13'd4010, 13'd4016, 13'd4024, 13'd4033,
        13'd4042, 13'd4052, 13'd4063, 13'd4074, 13'd4084,
        13'd4094, 13'd4102, 13'd4109, 13'd4115, 13'd4119,
        13'd4123, 13'd4127, 13'd4131, 13'd4135, 13'd4139,
        13'd4144, 13'd4149, 13'd4155, 13'd4161, 13'd4168,
        13'd4176, 13'd4186, 13'd4195, 13'd4200, 13'd4200
    };

    // Curve point at an index; indexes past the end read as the top code
    function automatic logic [12:0] curve_mv(input logic on_batt, input logic [6:0] idx);
        logic [12:0] mv;
        mv = 13'h1FFF;
        if (idx <= IDX_LAST) begin
            mv = on_batt ? CURVE_DIS[idx] : CURVE_CHG[idx];
        end
        return mv;
    endfunction

    // True for 0, 10, 20 ... 100
    function automatic logic is_tens(input logic [6:0] pct);
        return pct inside {7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
                           7'd60, 7'd70, 7'd80, 7'd90, 7'd100};
    endfunction

endpackage

// File: hw/rtl/bpt_ram.sv
// Generic single-port-write, registered-read RAM.
module bpt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: hw/rtl/battery_percent_tracker.sv
// Battery percent tracker top level: curve lookup, display smoothing and flags.
//
// Each request on the input stream (voltage in tdata, supply state in tuser) yields one
// result: the measured percent from the discharge or charge curve, the smoothed display
// percent and the change, power-off and log flags. The curve is walked one point per
// clock, up to the first point at or above the voltage. The measured percent is the
// index of that point, or 100 when the voltage lies above the whole curve. The next
// request can be accepted in the cycle after the result is formed. The display
// state lives in a one-entry RAM that is read on acceptance and written back at the end.
// One request is worked on at a time; the result sits in an output register so the next
// request is taken while it waits. Configuration writes are always accepted.
module battery_percent_tracker
    import bpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [12:0] battery_millivolt, [15:13] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] supply_state
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [6:0] measured_percent, [13:7] shown_percent
    output logic [2:0]  o_m_axis_tuser,   // [0] percent_changed, [1] power_off_request,
                                          // [2] log_event
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_fsm        r_fsm, n_fsm;
    logic [12:0] r_mv;
    logic [1:0]  r_sup;
    logic [6:0]  r_idx, n_idx;
    logic [6:0]  r_meas, n_meas;
    logic        r_st_vld;

    logic [6:0]  r_hold_thr;
    logic [7:0]  r_hold_lim;
    logic [6:0]  r_log_lim;

    logic        r_out_vld;
    logic [6:0]  r_out_meas;
    logic [6:0]  r_out_shown;
    logic        r_out_chg;
    logic        r_out_pwr;
    logic        r_out_log;

    logic        in_acc;
    logic        on_batt;
    logic        charging;
    logic        hit;
    logic        upd_go;
    logic [15:0] rd_raw;
    t_state      st_cur;
    t_state      st_new;
    logic        chg;
    logic        log_ev;
    logic [6:0]  d;
    logic [7:0]  h;

    assign o_s_axis_tready = (r_fsm == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign on_batt         = (r_sup == SUP_BATTERY);
    assign charging        = (r_sup == SUP_CHARGING);
    assign hit             = (r_mv <= curve_mv(on_batt, r_idx));
    assign upd_go          = (r_fsm == S_UPD) && (!r_out_vld || i_m_axis_tready);

    // State store, read at acceptance and written back when the result is formed
    bpt_ram #(
        .WIDTH (StateW),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (upd_go),
        .i_wr_addr (1'b0),
        .i_wr_data (st_new),
        .i_rd_en   (in_acc),
        .i_rd_addr (1'b0),
        .o_rd_data (rd_raw)
    );

    // Unwritten entry reads as the reset state
    always_comb begin
        if (r_st_vld) begin
            st_cur = t_state'(rd_raw);
        end else begin
            st_cur = '{display: PCT_INVALID, first: 1'b1, hold: 8'd0};
        end
    end

    // Sequencer: idle, curve walk, update
    always_comb begin
        n_fsm  = r_fsm;
        n_idx  = r_idx;
        n_meas = r_meas;
        case (r_fsm)
            S_IDLE: begin
                n_idx = 7'd0;
                if (in_acc) begin
                    n_fsm = S_WALK;
                end
            end
            S_WALK: begin
                if (hit) begin
                    n_meas = r_idx;
                    n_fsm  = S_UPD;
                end else if (r_idx == IDX_LAST) begin
                    n_meas = PCT_FULL;
                    n_fsm  = S_UPD;
                end else begin
                    n_idx = r_idx + 7'd1;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // Display update
    always_comb begin
        d   = st_cur.display;
        h   = st_cur.hold;
        chg = st_cur.first;
        if (d == PCT_INVALID) begin
            d   = r_meas;
            chg = 1'b1;
        end
        if (on_batt && (r_meas < d)) begin
            d   = d - 7'd1;
            chg = 1'b1;
        end else if (charging) begin
            if ((r_meas < d) && (r_meas >= r_hold_thr)) begin
                h = h + 8'd1;
            end
            if ((r_meas > d) || (h == r_hold_lim)) begin
                d   = (d >= PCT_FULL) ? PCT_FULL : d + 7'd1;
                chg = 1'b1;
                h   = 8'd0;
            end
        end
        log_ev = chg && is_tens(d) && (d <= r_log_lim);
        st_new = '{display: d, first: 1'b0, hold: h};
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_st_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (upd_go) begin
                r_st_vld  <= 1'b1;
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr <= RST_HOLD_THR;
            r_hold_lim <= RST_HOLD_LIM;
            r_log_lim  <= RST_LOG_LIM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HOLD_THR: r_hold_thr <= i_cfg_data[6:0];
                REG_HOLD_LIM: r_hold_lim <= i_cfg_data;
                REG_LOG_LIM:  r_log_lim  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_meas <= n_meas;
        if (in_acc) begin
            r_mv  <= i_s_axis_tdata[12:0];
            r_sup <= i_s_axis_tuser;
        end
        if (upd_go) begin
            r_out_meas  <= r_meas;
            r_out_shown <= d;
            r_out_chg   <= chg;
            r_out_pwr   <= on_batt && (r_mv < DIS_MIN_MV);
            r_out_log   <= log_ev;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out_shown, r_out_meas};
    assign o_m_axis_tuser  = {r_out_log, r_out_pwr, r_out_chg};

    // Checks
    a_acc_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_fsm == S_WALK))
        else $error("accepted request did not start the curve walk");

    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_WALK) |-> (r_idx <= IDX_LAST))
        else $error("curve walk ran past the last point");

    a_meas_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_UPD) |-> (r_meas <= PCT_FULL))
        else $error("measured percent out of range");

    a_shown_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_shown <= PCT_FULL))
        else $error("shown percent out of range");

    a_log_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_log) |-> r_out_chg)
        else $error("log event without a change");

endmodule

// File: tb/bpt_stream_checker.sv
// Stream checker for the battery percent tracker: tracks config, predicts each reading, compares.
module bpt_stream_checker
    import bpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick requests into the block
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_tdata,     // [12:0] battery_millivolt, [15:13] zero
    input  logic [1:0]  i_req_tuser,     // [1:0] supply_state
    // Readings out of the block
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_tdata,     // [6:0] measured_percent, [13:7] shown_percent
    input  logic [2:0]  i_res_tuser,     // [0] percent_changed, [1] power_off_request,
                                         // [2] log_event
    // Configuration writes
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Status toward the testbench top
    output int unsigned o_fail_count,
    output int unsigned o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [6:0] measured;
        logic [6:0] shown;
        logic       changed;
        logic       power_off;
        logic       log_event;
    } t_reading;

    // Shadow copy of the tracker state and its registers
    logic [6:0] disp_pct;
    logic       first_tick;
    logic [7:0] hold_cnt;
    logic [6:0] hold_thr;
    logic [7:0] hold_lim;
    logic [6:0] log_lim;

    t_reading    readings_due[$];
    int unsigned n_fail = 0;

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            n_fail++;
        end
    endfunction

    // One tick of the tracker: curve lookup, display step and flags
    function automatic t_reading track_tick(input logic [12:0] mv, input logic [1:0] sup);
        t_reading   r;
        logic       on_batt;
        logic       charging;
        logic       found;
        logic [12:0] point;
        on_batt  = (sup == SUP_BATTERY);
        charging = (sup == SUP_CHARGING);

        // first curve point at or above the voltage, full if none
        r.measured = PCT_FULL;
        found      = 1'b0;
        for (int k = 0; k < CurveLen; k++) begin
            point = on_batt ? CURVE_DIS[k] : CURVE_CHG[k];
            if (!found && mv <= point) begin
                r.measured = 7'(k);
                found      = 1'b1;
            end
        end

        r.changed  = first_tick;
        first_tick = 1'b0;
        if (disp_pct == PCT_INVALID) begin
            disp_pct  = r.measured;
            r.changed = 1'b1;
        end

        if (on_batt && r.measured < disp_pct) begin
            disp_pct  = disp_pct - 7'd1;
            r.changed = 1'b1;
        end else if (charging) begin
            // lagging charge: count toward a forced rise (wraps at 256)
            if (r.measured < disp_pct && r.measured >= hold_thr) begin
                hold_cnt = hold_cnt + 8'd1;
            end
            if (r.measured > disp_pct || hold_cnt == hold_lim) begin
                disp_pct  = (disp_pct >= PCT_FULL - 7'd1) ? PCT_FULL : disp_pct + 7'd1;
                r.changed = 1'b1;
                hold_cnt  = 8'd0;
            end
        end

        r.shown     = disp_pct;
        r.power_off = on_batt && (mv < DIS_MIN_MV);
        r.log_event = r.changed && (disp_pct % 7'd10 == 7'd0) && (disp_pct <= log_lim);
        return r;
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            disp_pct   = PCT_INVALID;
            first_tick = 1'b1;
            hold_cnt   = 8'd0;
            hold_thr   = RST_HOLD_THR;
            hold_lim   = RST_HOLD_LIM;
            log_lim    = RST_LOG_LIM;
            readings_due.delete();
        end else begin
            // readings first: a request taken this edge cannot come out this edge
            if (i_res_valid && i_res_ready) begin
                if (readings_due.size() == 0) begin
                    $error("reading with no request outstanding: tdata %h tuser %h",
                           i_res_tdata, i_res_tuser);
                    n_fail++;
                end else begin
                    want = readings_due.pop_front();
                    compare_field("measured_percent", want.measured, i_res_tdata[6:0]);
                    compare_field("shown_percent", want.shown, i_res_tdata[13:7]);
                    compare_field("percent_changed", want.changed, i_res_tuser[0]);
                    compare_field("power_off_request", want.power_off, i_res_tuser[1]);
                    compare_field("log_event", want.log_event, i_res_tuser[2]);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HOLD_THR: hold_thr = i_cfg_data[6:0];
                    REG_HOLD_LIM: hold_lim = i_cfg_data;
                    REG_LOG_LIM:  log_lim  = i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (i_req_valid && i_req_ready) begin
                readings_due.push_back(track_tick(i_req_tdata[12:0], i_req_tuser));
            end
        end
        o_pending_count <= readings_due.size();
        o_fail_count    <= n_fail;
    end

endmodule

// File: tb/tb.sv
// Testbench top for the battery percent tracker: clock, reset, stimulus and verdict.
module tb
    import bpt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Supply codes with no display update
    localparam logic [1:0] SUP_OTHER  = 2'd2;
    localparam logic [1:0] SUP_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 110;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_PHASE = 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_ready;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        cfg_ready;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned cycle_cnt = 0;

    int          phase_id = 0;
    bit          quiet = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    battery_percent_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    bpt_stream_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_valid),
        .i_req_ready     (s_ready),
        .i_req_tdata     (s_tdata),
        .i_req_tuser     (s_tuser),
        .i_res_valid     (m_valid),
        .i_res_ready     (m_ready),
        .i_res_tdata     (m_tdata),
        .i_res_tuser     (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Reading sink: random stall bursts, one long hold-off, steady at the end
    initial begin
        int  stall_left;
        int  run_left;
        bit  long_done;
        stall_left = 0;
        run_left   = 0;
        long_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_done && phase_id == LONG_HOLD_PHASE) begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (run_left > 0) begin
                m_ready <= 1'b1;
                run_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_ready  <= 1'b1;
                run_left = $urandom_range(0, 24);
            end
        end
    end

    // Offer one tick request, with an occasional gap ahead of it
    task automatic send_tick(input logic [12:0] mv, input logic [1:0] sup);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {3'b000, mv};
        s_tuser <= sup;
        do @(posedge i_clk); while (!s_ready);
    endtask

    // Stop offering and wait until every reading is back and the block has settled
    task automatic drain_readings();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write_one(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic write_config(input logic [7:0] thr, input logic [7:0] lim,
                                input logic [7:0] logl);
        cfg_write_one(REG_HOLD_THR, thr);
        cfg_write_one(REG_HOLD_LIM, lim);
        cfg_write_one(REG_LOG_LIM, logl);
        cfg_valid <= 1'b0;
    endtask

    // Discharge and charge walks with random content, plus some noise
    task automatic run_walks(input int n_items);
        int sent;
        int len;
        int kind;
        int mv;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(4, 30);
            mv   = $urandom_range(3330, 4260);
            for (int k = 0; k < len && sent < n_items; k++) begin
                if (kind < 4) begin
                    send_tick(13'(mv), ($urandom_range(0, 15) == 0) ? SUP_OTHER : SUP_BATTERY);
                    mv = mv - $urandom_range(0, 12);
                    if (mv < 0) mv = 0;
                end else if (kind < 8) begin
                    send_tick(13'(mv), ($urandom_range(0, 15) == 0) ? SUP_UNUSED : SUP_CHARGING);
                    mv = mv + $urandom_range(0, 12);
                    if (mv > 8191) mv = 8191;
                end else begin
                    send_tick(13'($urandom_range(0, 8191)), 2'($urandom_range(0, 3)));
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first tick, curve edges, power-off boundary, idle supply codes
        send_tick(13'd0, SUP_BATTERY);
        send_tick(13'd8191, SUP_CHARGING);
        send_tick(13'd8191, SUP_CHARGING);
        send_tick(13'd3391, SUP_BATTERY);
        send_tick(13'd3390, SUP_BATTERY);
        send_tick(13'd4156, SUP_BATTERY);
        send_tick(13'd4157, SUP_BATTERY);
        send_tick(13'd4200, SUP_CHARGING);
        send_tick(13'd4201, SUP_CHARGING);
        send_tick(13'd3380, SUP_CHARGING);
        send_tick(13'd3381, SUP_CHARGING);
        send_tick(13'd3700, SUP_OTHER);
        send_tick(13'd3700, SUP_UNUSED);
        send_tick(13'd8191, SUP_UNUSED);
        send_tick(13'd4096, SUP_BATTERY);
        send_tick(13'd3600, SUP_CHARGING);
        drain_readings();

        // Mid-range settings
        phase_id = 1;
        write_config(8'($urandom_range(0, 100)), 8'($urandom_range(1, 10)),
                     8'($urandom_range(0, 100)));
        run_walks(200);
        drain_readings();

        // Limit zero: the hold count has to wrap before it forces a rise at full
        phase_id = LONG_HOLD_PHASE;
        write_config(8'd0, 8'd0, 8'd100);
        repeat (100) send_tick(13'd8191, SUP_CHARGING);
        repeat (262) send_tick(13'($urandom_range(3690, 3720)), SUP_CHARGING);
        drain_readings();

        // All-ones register data
        phase_id = 3;
        write_config(8'hFF, 8'hFF, 8'hFF);
        run_walks(150);
        drain_readings();

        // Top threshold, smallest limit, log band at 0 only
        phase_id = 4;
        write_config(8'd100, 8'd1, 8'd0);
        run_walks(100);
        drain_readings();

        // Final stretch with no idling on either side
        phase_id = 5;
        write_config(8'($urandom_range(60, 90)), 8'($urandom_range(1, 4)), 8'd100);
        quiet = 1'b1;
        run_walks(100);
        drain_readings();

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/bpt_pkg.sv
hw/rtl/bpt_ram.sv
hw/rtl/battery_percent_tracker.sv
tb/bpt_stream_checker.sv
tb/tb.sv
